>>> rtl/soft_timer_table_unit_defines.svh
// Assertion macros shared by the timer table RTL.
`ifndef SOFT_TIMER_TABLE_UNIT_DEFINES_SVH
`define SOFT_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define STT_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define STT_NEVER(name, clk, rstn, expr, msg) \
    `STT_ASSERT(name, clk, rstn, !(expr), msg)
`else
`define STT_ASSERT(name, clk, rstn, prop, msg)
`define STT_NEVER(name, clk, rstn, expr, msg)
`endif

`endif

>>> rtl/stt_pkg.sv
// Types, codes and constants of the timer table.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam logic [31:0] MS_WRAP_LIMIT = 32'd1000;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_SET     = 3'd1,
        ACT_KILL    = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_SERVICE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ID     = 2'd1,
        ST_ACTIVE     = 2'd2,
        ST_NO_HANDLER = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic tick;
        logic set;
        logic kill;
        logic clr;
        logic svc;       // snapshot expiries, wrap ms count
        logic load_exp;  // emit expiry result for the scan index
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result
        logic any_exp;   // some active slot has expired now
        logic cur_bit;   // pending expiry at the scan index
        logic last_bit;  // that expiry is the only one left
    } t_dp_stat;

endpackage

>>> rtl/stt_dp.sv
// Timer table datapath: slot lanes, ms count, expiry flags, output register.
`timescale 1ns / 1ps
`include "soft_timer_table_unit_defines.svh"

module stt_dp
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [IW-1:0]          i_idx,
    output t_dp_stat               o_stat,
    input  logic [7:0]             i_timer_id,
    input  logic [15:0]            i_period,
    input  logic                   i_handler_present,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [7:0]             o_echo_id,
    output logic                   o_expired_valid,
    output logic [7:0]             o_expired_id,
    output logic                   o_last,
    output logic [31:0]            o_ms_now
);

    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [15:0]           r_period [NUM_TIMERS];
    logic [15:0]           n_period [NUM_TIMERS];
    logic [15:0]           r_count  [NUM_TIMERS];
    logic [15:0]           n_count  [NUM_TIMERS];
    logic [31:0]           r_ms, n_ms;
    logic [NUM_TIMERS-1:0] r_flags, n_flags;

    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [7:0]            r_echo, n_echo;
    logic                  r_exp_valid, n_exp_valid;
    logic [7:0]            r_exp_id, n_exp_id;
    logic                  r_last, n_last;
    logic [31:0]           r_ms_now, n_ms_now;

    logic                  w_id_ok;
    logic [IW-1:0]         w_sel;
    logic                  w_sel_active;
    logic                  w_do_set;
    t_status               w_set_status;
    logic [NUM_TIMERS-1:0] w_exp;
    logic [NUM_TIMERS-1:0] w_idx_bit;
    logic [31:0]           w_ms_wrap;
    logic                  w_out_free;
    logic                  w_load;

    // Id decode and set checks
    assign w_id_ok      = (i_timer_id != 8'd0) && (i_timer_id <= 8'(NUM_TIMERS));
    assign w_sel        = IW'(i_timer_id - 8'd1);
    assign w_sel_active = r_active[w_sel];
    assign w_do_set     = i_cmd.set && w_id_ok && !w_sel_active && i_handler_present;

    always_comb begin
        priority if (!w_id_ok) begin
            w_set_status = ST_BAD_ID;
        end else if (w_sel_active) begin
            w_set_status = ST_ACTIVE;
        end else if (!i_handler_present) begin
            w_set_status = ST_NO_HANDLER;
        end else begin
            w_set_status = ST_OK;
        end
    end

    // Per-lane expiry compare
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_exp[i] = r_active[i] && (r_count[i] >= r_period[i]);
        end
    end

    assign w_ms_wrap = (r_ms > MS_WRAP_LIMIT) ? 32'd0 : r_ms;
    assign w_idx_bit = NUM_TIMERS'(1) << i_idx;

    assign o_stat.out_free = w_out_free;
    assign o_stat.any_exp  = |w_exp;
    assign o_stat.cur_bit  = r_flags[i_idx];
    assign o_stat.last_bit = ((r_flags & ~w_idx_bit) == '0);

    // Slot lanes, ms count and pending flags
    always_comb begin
        n_active = r_active;
        n_period = r_period;
        n_count  = r_count;
        n_ms     = r_ms;
        n_flags  = r_flags;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (i_cmd.tick && r_count[i] != CNT_MAX) begin
                n_count[i] = r_count[i] + 16'd1;
            end
            if (w_id_ok && i_timer_id == 8'(i + 1)) begin
                if (w_do_set) begin
                    n_active[i] = 1'b1;
                    n_period[i] = i_period;
                    n_count[i]  = 16'd0;
                end
                if (i_cmd.kill) begin
                    n_active[i] = 1'b0;
                    n_period[i] = 16'd0;
                    n_count[i]  = 16'd0;
                end
                if (i_cmd.clr) begin
                    n_count[i] = 16'd0;
                end
            end
            if (i_cmd.svc && w_exp[i]) begin
                n_count[i] = 16'd0;
            end
        end
        if (i_cmd.tick) begin
            n_ms = r_ms + 32'd1;
        end
        if (i_cmd.svc) begin
            n_ms    = w_ms_wrap;
            n_flags = w_exp;
        end
        if (i_cmd.load_exp) begin
            n_flags = r_flags & ~w_idx_bit;
        end
    end

    // Output register
    assign w_out_free = !r_valid || !i_stall;
    assign w_load     = i_cmd.set || i_cmd.kill || i_cmd.clr || i_cmd.load_exp
                        || (i_cmd.svc && !(|w_exp));

    always_comb begin
        n_valid     = r_valid && i_stall;
        n_status    = r_status;
        n_echo      = r_echo;
        n_exp_valid = r_exp_valid;
        n_exp_id    = r_exp_id;
        n_last      = r_last;
        n_ms_now    = r_ms_now;
        if (w_load) begin
            n_valid     = 1'b1;
            n_status    = ST_OK;
            n_echo      = 8'd0;
            n_exp_valid = 1'b0;
            n_exp_id    = 8'd0;
            n_last      = 1'b1;
            n_ms_now    = r_ms + 32'd1;
            if (i_cmd.set) begin
                n_status = w_set_status;
                n_echo   = (w_set_status == ST_OK) ? i_timer_id : 8'd0;
            end
            if (i_cmd.kill) begin
                n_status = w_id_ok ? ST_OK : ST_BAD_ID;
            end
            if (i_cmd.clr) begin
                n_status = w_id_ok ? ST_OK : ST_BAD_ID;
                n_echo   = w_id_ok ? i_timer_id : 8'd0;
            end
            if (i_cmd.svc) begin
                n_ms_now = w_ms_wrap + 32'd1;
            end
            if (i_cmd.load_exp) begin
                n_exp_valid = 1'b1;
                n_exp_id    = 8'(i_idx) + 8'd1;
                n_last      = o_stat.last_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_ms     <= 32'd0;
            r_flags  <= '0;
            r_valid  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_period[i] <= 16'd0;
                r_count[i]  <= 16'd0;
            end
        end else begin
            r_active <= n_active;
            r_ms     <= n_ms;
            r_flags  <= n_flags;
            r_valid  <= n_valid;
            r_period <= n_period;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_echo      <= n_echo;
        r_exp_valid <= n_exp_valid;
        r_exp_id    <= n_exp_id;
        r_last      <= n_last;
        r_ms_now    <= n_ms_now;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_echo_id       = r_echo;
    assign o_expired_valid = r_exp_valid;
    assign o_expired_id    = r_exp_id;
    assign o_last          = r_last;
    assign o_ms_now        = r_ms_now;

    // A result is only loaded into a free output register
    `STT_ASSERT(a_load_free, i_clk, i_rst_n, w_load |-> w_out_free, "load into busy output")
    // Pending expiries belong to active slots only
    `STT_NEVER(a_flag_active, i_clk, i_rst_n, |(r_flags & ~r_active), "flag on idle slot")

endmodule

>>> rtl/stt_ctrl.sv
// Timer table controller: request decode and expiry scan sequencer.
`timescale 1ns / 1ps
`include "soft_timer_table_unit_defines.svh"

module stt_ctrl
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_action,
    output logic          o_stall,
    input  t_dp_stat      i_stat,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_idx
);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = !i_stat.out_free;
                if (i_valid && i_stat.out_free) begin
                    unique case (t_action'(i_action))
                        ACT_TICK:  o_cmd.tick = 1'b1;
                        ACT_SET:   o_cmd.set  = 1'b1;
                        ACT_KILL:  o_cmd.kill = 1'b1;
                        ACT_CLEAR: o_cmd.clr  = 1'b1;
                        ACT_SERVICE: begin
                            o_cmd.svc = 1'b1;
                            if (i_stat.any_exp) begin
                                n_state = S_SCAN;
                                n_idx   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // one slot per cycle; hold on a pending expiry until output frees
                if (i_stat.cur_bit) begin
                    if (i_stat.out_free) begin
                        o_cmd.load_exp = 1'b1;
                        n_idx = r_idx + IW'(1);
                        if (i_stat.last_bit) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idx = r_idx;

    // Expiry results come only from a pending slot during a scan
    `STT_ASSERT(a_exp_pending, i_clk, i_rst_n, o_cmd.load_exp |-> (r_state == S_SCAN && i_stat.cur_bit), "expiry without pending slot")
    // A scan ends only on its final expiry result
    `STT_ASSERT(a_scan_end, i_clk, i_rst_n, (r_state == S_SCAN && n_state == S_IDLE) |-> (o_cmd.load_exp && i_stat.last_bit), "scan ended early")

endmodule

>>> rtl/soft_timer_table_unit.sv
// Channel   | dir | handshake          | payload
// request   | in  | i_valid / o_stall  | i_action, i_timer_id, i_period, i_handler_present
// result    | out | o_valid / i_stall  | o_status, o_echo_id, o_expired_valid, o_expired_id,
//           |     |                    | o_last, o_ms_now
//
// Set, kill and clear place their result in the output register; tick gives no result.
// Service with no expired slot loads its result; otherwise the scan sequencer walks the
// slots up to the last expired one (at most NUM_TIMERS), one slot per cycle when not stalled.
// A stalled result holds the output register; the scan waits, and requests stall.
// Synchronous active-low reset clears all slots and the ms count.
`timescale 1ns / 1ps

module soft_timer_table_unit
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_timer_id,
    input  logic [15:0] i_period,
    input  logic        i_handler_present,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_echo_id,
    output logic        o_expired_valid,
    output logic [7:0]  o_expired_id,
    output logic        o_last,
    output logic [31:0] o_ms_now
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [IW-1:0] w_idx;

    stt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_idx    (w_idx)
    );

    stt_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_idx             (w_idx),
        .o_stat            (w_stat),
        .i_timer_id        (i_timer_id),
        .i_period          (i_period),
        .i_handler_present (i_handler_present),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_echo_id         (o_echo_id),
        .o_expired_valid   (o_expired_valid),
        .o_expired_id      (o_expired_id),
        .o_last            (o_last),
        .o_ms_now          (o_ms_now)
    );

endmodule
